>>> rtl/gou_pkg.sv
package gou_pkg;

  // Moment memory geometry (depth is a power of two)
  localparam int MOMENT_DEPTH = 4096;
  localparam int MOM_AW       = $clog2(MOMENT_DEPTH);

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_LR    = 3'd1;
  localparam logic [2:0] REG_BETA1 = 3'd2;
  localparam logic [2:0] REG_BETA2 = 3'd3;
  localparam logic [2:0] REG_EPS   = 3'd4;

  // Update rules
  localparam logic [1:0] MODE_SGD  = 2'd0;
  localparam logic [1:0] MODE_MOM  = 2'd1;
  localparam logic [1:0] MODE_ADAM = 2'd2;

  // Item operations
  localparam logic OP_BEGIN  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Register reset values
  localparam logic [31:0] LR_RST    = 32'd4294967;
  localparam logic [31:0] BETA1_RST = 32'd3865470566;
  localparam logic [31:0] BETA2_RST = 32'd4290672329;
  localparam logic [23:0] EPS_RST   = 24'd1;

  // One in Q1.32
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  // Clip to signed 32 bits; bit 32 flags a clip
  function automatic logic [32:0] clamp32(input logic signed [65:0] x);
    logic [32:0] res;
    if (x > S32_MAX) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (x < S32_MIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, x[31:0]};
    end
    return res;
  endfunction

endpackage

>>> rtl/gradient_optimizer_update.sv
// Channel   Direction  Handshake            Payload
// in_*      input      in_valid / in_stall  operation, element_index, weight, gradient
// out_*     output     out_valid/out_stall  updated_weight, result_index, saturated
// cfg       APB        psel/penable/pready  mode, learning_rate, betas, epsilon
//
// One item at a time. Adam uses a shared divider that retires one quotient bit per cycle
// for three passes (two when the second moment clips), and the square root
// runs 32 steps. After reset a clearing pass zeroes both moment memories;
// input stays stalled meanwhile. A waiting result does not block the next item.
module gradient_optimizer_update import gou_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [11:0] in_element_index,
  input  logic signed [31:0] in_weight_value,
  input  logic signed [31:0] in_gradient_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_updated_weight,
  output logic [11:0] out_result_index,
  output logic        out_saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BP1   = 5'd1;
  localparam logic [4:0] S_BP2   = 5'd2;
  localparam logic [4:0] S_RD    = 5'd3;
  localparam logic [4:0] S_M1    = 5'd4;
  localparam logic [4:0] S_M2    = 5'd5;
  localparam logic [4:0] S_LR    = 5'd6;
  localparam logic [4:0] S_LRF   = 5'd7;
  localparam logic [4:0] S_GG    = 5'd8;
  localparam logic [4:0] S_V0    = 5'd9;
  localparam logic [4:0] S_V1    = 5'd10;
  localparam logic [4:0] S_V2    = 5'd11;
  localparam logic [4:0] S_V3    = 5'd12;
  localparam logic [4:0] S_VW    = 5'd13;
  localparam logic [4:0] S_DIV   = 5'd14;
  localparam logic [4:0] S_QSAT  = 5'd15;
  localparam logic [4:0] S_SQ    = 5'd16;
  localparam logic [4:0] S_STEPM = 5'd17;
  localparam logic [4:0] S_WFIN  = 5'd18;
  localparam logic [4:0] S_FIN   = 5'd19;

  localparam logic [1:0] DSEL_MHAT = 2'd0;
  localparam logic [1:0] DSEL_VHAT = 2'd1;
  localparam logic [1:0] DSEL_STEP = 2'd2;

  // Configuration registers
  logic [1:0]  mode_r;
  logic [31:0] lr_r, b1_r, b2_r;
  logic [23:0] eps_r;

  // Control
  logic [4:0]  state_r;
  logic [1:0]  dsel_r;
  logic [5:0]  cnt_r;
  logic        clr_busy_r;
  logic [MOM_AW-1:0] clr_addr_r;
  logic [32:0] p1_r, p2_r;
  logic        out_valid_r;

  // Datapath
  logic [11:0] idx_r;
  logic [MOM_AW-1:0] addr_r;
  logic signed [31:0] w_r, g_r, m_r, lrv_r, nw_r;
  logic        sat_r, neg_r;
  logic signed [64:0] t1_r, prod_r;
  logic [63:0] gg_r;
  logic [96:0] acc_r;
  logic [40:0] rem_r, divs_r;
  logic [63:0] dq_r;
  logic [31:0] q_r;
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r;
  logic [31:0] m_rd_r;
  logic [63:0] v_rd_r;
  logic signed [31:0] ow_r;
  logic [11:0] oidx_r;
  logic        osat_r;

  // Moment memories
  logic [31:0] fmem [MOMENT_DEPTH];
  logic [63:0] smem [MOMENT_DEPTH];
  logic              fm_we, sm_we;
  logic [MOM_AW-1:0] fm_wa, sm_wa;
  logic [31:0]       fm_wd;
  logic [63:0]       sm_wd;

  logic        in_acc, cfg_wr, out_load;
  logic [32:0] wb1, wb2, c1_raw, c2_raw, c1, c2;
  logic signed [65:0] gw;
  logic signed [66:0] m_sum;
  logic [32:0] m_cl, lr_cl, w_cl;
  logic signed [65:0] lr_diff, w_sum;
  logic [31:0] mul_a;
  logic [32:0] mul_b;
  logic [64:0] mul_p;
  logic [41:0] div_t;
  logic        div_ge;
  logic [40:0] rem_nxt;
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [32:0] d_raw, d_val;
  logic [63:0] v_new;
  logic        q_clip, v_clip;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = clr_busy_r || (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  assign out_valid          = out_valid_r;
  assign out_updated_weight = ow_r;
  assign out_result_index   = oidx_r;
  assign out_saturated      = osat_r;

  // Blend weights and bias corrections
  assign wb1    = ONE_Q32 - {1'b0, b1_r};
  assign wb2    = ONE_Q32 - {1'b0, b2_r};
  assign c1_raw = ONE_Q32 - p1_r;
  assign c2_raw = ONE_Q32 - p2_r;
  assign c1     = (c1_raw == 33'd0) ? ONE_Q32 : c1_raw;
  assign c2     = (c2_raw == 33'd0) ? ONE_Q32 : c2_raw;

  // First moment blend, rounded half up
  assign gw    = g_r * $signed({1'b0, wb1});
  assign m_sum = 67'(t1_r) + 67'(gw) + 67'sd2147483648;
  assign m_cl  = clamp32(66'($signed(m_sum[66:32])));

  // Scaled step for SGD and momentum
  assign lr_diff = 66'(w_r) - 66'($signed(prod_r[64:32]));
  assign lr_cl   = clamp32(lr_diff);

  // Adam final weight
  assign w_sum = neg_r ? (66'(w_r) + $signed({2'b00, dq_r}))
                       : (66'(w_r) - $signed({2'b00, dq_r}));
  assign w_cl  = clamp32(w_sum);

  assign v_new = acc_r[95:32];

  // Clip checks on the corrected moments
  assign q_clip = neg_r ? (dq_r > 64'h8000_0000) : (dq_r > 64'h7FFF_FFFF);
  assign v_clip = {1'b0, v_new[63:32]} >= c2;

  // Shared unsigned multiplier, operands picked by state
  always_comb begin
    case (state_r)
      S_BP1: begin
        mul_a = b1_r;
        mul_b = p1_r;
      end
      S_BP2: begin
        mul_a = b2_r;
        mul_b = p2_r;
      end
      S_V0: begin
        mul_a = v_rd_r[31:0];
        mul_b = {1'b0, b2_r};
      end
      S_V1: begin
        mul_a = v_rd_r[63:32];
        mul_b = {1'b0, b2_r};
      end
      S_V2: begin
        mul_a = gg_r[31:0];
        mul_b = wb2;
      end
      S_V3: begin
        mul_a = gg_r[63:32];
        mul_b = wb2;
      end
      S_STEPM: begin
        mul_a = q_r;
        mul_b = {1'b0, lr_r};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 33'd0;
      end
    endcase
  end
  assign mul_p = 65'(mul_a) * 65'(mul_b);

  // Restoring divider step, one quotient bit
  assign div_t   = {rem_r, dq_r[63]};
  assign div_ge  = div_t >= {1'b0, divs_r};
  assign rem_nxt = div_ge ? 41'(div_t - {1'b0, divs_r}) : div_t[40:0];

  // Square root step
  assign sq_t  = sq_res_r + sq_bit_r;
  assign sq_ge = sq_x_r >= sq_t;

  // Denominator of the Adam step
  assign d_raw = 33'(sq_res_r[31:0]) + 33'(eps_r);
  assign d_val = (d_raw == 33'd0) ? 33'd1 : d_raw;

  // Memory write ports: clearing pass has priority
  assign fm_we = clr_busy_r || (state_r == S_M2);
  assign fm_wa = clr_busy_r ? clr_addr_r : addr_r;
  assign fm_wd = clr_busy_r ? 32'd0 : m_cl[31:0];
  assign sm_we = clr_busy_r || (state_r == S_VW);
  assign sm_wa = clr_busy_r ? clr_addr_r : addr_r;
  assign sm_wd = clr_busy_r ? 64'd0 : v_new;

  always_ff @(posedge clk) begin
    if (fm_we) begin
      fmem[fm_wa] <= fm_wd;
    end
    m_rd_r <= fmem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (sm_we) begin
      smem[sm_wa] <= sm_wd;
    end
    v_rd_r <= smem[addr_r];
  end

  // Register read
  always_comb begin
    case (paddr[4:2])
      REG_MODE:  prdata = {30'd0, mode_r};
      REG_LR:    prdata = lr_r;
      REG_BETA1: prdata = b1_r;
      REG_BETA2: prdata = b2_r;
      REG_EPS:   prdata = {8'd0, eps_r};
      default:   prdata = 32'd0;
    endcase
  end

  // Register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SGD;
      lr_r   <= LR_RST;
      b1_r   <= BETA1_RST;
      b2_r   <= BETA2_RST;
      eps_r  <= EPS_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MODE:  mode_r <= pwdata[1:0];
        REG_LR:    lr_r   <= pwdata;
        REG_BETA1: b1_r   <= pwdata;
        REG_BETA2: b2_r   <= pwdata;
        REG_EPS:   eps_r  <= pwdata[23:0];
        default:   ;
      endcase
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == MOM_AW'(MOMENT_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ow_r   <= nw_r;
      oidx_r <= idx_r;
      osat_r <= sat_r;
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p1_r    <= ONE_Q32;
      p2_r    <= ONE_Q32;
      cnt_r   <= 6'd0;
      dsel_r  <= DSEL_MHAT;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_operation == OP_BEGIN) begin
              state_r <= (mode_r == MODE_ADAM) ? S_BP1 : S_IDLE;
            end else begin
              case (mode_r)
                MODE_SGD:  state_r <= S_LR;
                MODE_MOM:  state_r <= S_RD;
                MODE_ADAM: state_r <= S_RD;
                default:   state_r <= S_FIN;
              endcase
            end
          end
        end
        S_BP1: begin
          p1_r    <= mul_p[64:32];
          state_r <= S_BP2;
        end
        S_BP2: begin
          p2_r    <= mul_p[64:32];
          state_r <= S_IDLE;
        end
        S_RD:  state_r <= S_M1;
        S_M1:  state_r <= S_M2;
        S_M2:  state_r <= (mode_r == MODE_MOM) ? S_LR : S_GG;
        S_LR:  state_r <= S_LRF;
        S_LRF: state_r <= S_FIN;
        S_GG:  state_r <= S_V0;
        S_V0:  state_r <= S_V1;
        S_V1:  state_r <= S_V2;
        S_V2:  state_r <= S_V3;
        S_V3:  state_r <= S_VW;
        S_VW: begin
          cnt_r   <= 6'd0;
          dsel_r  <= DSEL_MHAT;
          state_r <= S_DIV;
        end
        S_DIV: begin
          // count wraps to zero after the last bit
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 6'd63) begin
            case (dsel_r)
              DSEL_MHAT: state_r <= S_QSAT;
              DSEL_VHAT: state_r <= S_SQ;
              default:   state_r <= S_WFIN;
            endcase
          end
        end
        S_QSAT: begin
          cnt_r <= 6'd0;
          if (v_clip) begin
            state_r <= S_SQ;
          end else begin
            dsel_r  <= DSEL_VHAT;
            state_r <= S_DIV;
          end
        end
        S_SQ: begin
          if (cnt_r == 6'd31) begin
            cnt_r   <= 6'd0;
            state_r <= S_STEPM;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_STEPM: begin
          dsel_r  <= DSEL_STEP;
          state_r <= S_DIV;
        end
        S_WFIN: state_r <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_r  <= in_element_index;
          addr_r <= in_element_index[MOM_AW-1:0];
          w_r    <= in_weight_value;
          g_r    <= in_gradient_value;
          lrv_r  <= in_gradient_value;
          nw_r   <= in_weight_value;
          sat_r  <= 1'b0;
        end
      end
      S_M1: begin
        t1_r <= $signed(m_rd_r) * $signed({1'b0, b1_r});
      end
      S_M2: begin
        m_r   <= m_cl[31:0];
        lrv_r <= m_cl[31:0];
        sat_r <= sat_r | m_cl[32];
      end
      S_LR: begin
        prod_r <= lrv_r * $signed({1'b0, lr_r}) + 65'sd2147483648;
      end
      S_LRF: begin
        nw_r  <= lr_cl[31:0];
        sat_r <= sat_r | lr_cl[32];
      end
      S_GG: begin
        gg_r <= g_r * g_r;
      end
      S_V0: acc_r <= 97'(33'h0_8000_0000) + 97'(mul_p);
      S_V1: acc_r <= acc_r + 97'({mul_p, 32'd0});
      S_V2: acc_r <= acc_r + 97'(mul_p);
      S_V3: acc_r <= acc_r + 97'({mul_p, 32'd0});
      S_VW: begin
        neg_r  <= m_r[31];
        rem_r  <= 41'd0;
        dq_r   <= {(m_r[31] ? (32'd0 - m_r) : m_r), 32'd0};
        divs_r <= 41'(c1);
      end
      S_DIV: begin
        rem_r <= rem_nxt;
        dq_r  <= {dq_r[62:0], div_ge};
        if (cnt_r == 6'd63 && dsel_r == DSEL_VHAT) begin
          sq_x_r   <= {dq_r[62:0], div_ge};
          sq_res_r <= 64'd0;
          sq_bit_r <= 64'h4000_0000_0000_0000;
        end
      end
      S_QSAT: begin
        if (neg_r && dq_r > 64'h8000_0000) begin
          q_r <= 32'h8000_0000;
        end else if (!neg_r && dq_r > 64'h7FFF_FFFF) begin
          q_r <= 32'h7FFF_FFFF;
        end else begin
          q_r <= dq_r[31:0];
        end
        sat_r <= sat_r | q_clip | v_clip;
        if (v_clip) begin
          sq_x_r   <= '1;
          sq_res_r <= 64'd0;
          sq_bit_r <= 64'h4000_0000_0000_0000;
        end else begin
          rem_r  <= 41'(v_new[63:32]);
          dq_r   <= {v_new[31:0], 32'd0};
          divs_r <= 41'(c2);
        end
      end
      S_SQ: begin
        if (sq_ge) begin
          sq_x_r   <= sq_x_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      S_STEPM: begin
        rem_r  <= 41'd0;
        dq_r   <= mul_p[63:0];
        divs_r <= {d_val, 8'd0};
      end
      S_WFIN: begin
        nw_r  <= w_cl[31:0];
        sat_r <= sat_r | w_cl[32];
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/gou_checker.sv
module gou_checker import gou_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [31:0] out_updated_weight,
  input logic [11:0] out_result_index,
  input logic        out_saturated
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_updated_weight)
      && $stable(out_result_index) && $stable(out_saturated))
    else $error("stalled result beat changed");

  // Input is stalled right after reset is applied, as the clearing pass begins
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  // An accepted update beat holds the input stalled afterwards
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_UPDATE |=> in_stall)
    else $error("update beat did not hold the input");

  // A begin step beat never produces a result
  a_begin_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation == OP_BEGIN |=> !$rose(out_valid))
    else $error("begin step produced a result");

endmodule

bind gradient_optimizer_update gou_checker u_gou_checker (.*);
